FILE: sv/bblc_pkg.sv
// Shared constants and codes for the byte-budget LRU cluster cache.
package bblc_pkg;

   localparam int NLIST     = 1024;
   localparam int IDX_W     = $clog2(NLIST);
   localparam int CNT_W     = 20;
   localparam int ID_BYTES  = 8;
   localparam int CODE_W    = 9;
   localparam int FACT_W    = CODE_W + 1;
   localparam int SIZE_W    = CNT_W + FACT_W;
   localparam int OFF_W     = 48;
   localparam int BYTES_W   = 40;
   localparam int TOT_W     = IDX_W + 1;
   localparam int CTR_W     = 32;
   localparam int HELD_W    = SIZE_W + 1;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_ACCESS = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [2:0] ST_LOADED   = 3'd0;
   localparam logic [2:0] ST_HIT      = 3'd1;
   localparam logic [2:0] ST_FETCHED  = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_CLEARED  = 3'd4;

   localparam logic [2:0] CSR_BASE  = 3'd0;
   localparam logic [2:0] CSR_CODE  = 3'd1;
   localparam logic [2:0] CSR_LIMIT = 3'd2;

   localparam logic [CODE_W-1:0] CODE_RESET = 9'd8;

endpackage

FILE: sv/bblc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bblc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: sv/byte_budget_lru_cluster_cache_top.sv
// Top level of the byte-budget LRU cluster cache.
//
//  channel   direction  handshake                 payload
//  req_      in         req_tvalid/req_tready     tuser op, tdata index+count
//  rsp_      out        rsp_tvalid/rsp_tready     tuser status, tdata results
//  csr_      in/out     psel+penable, pready=1    base, code bytes, byte limit
//
// A clear sweeps the residency memory. A miss walks the count memory for the
// offset over the lists below its index, then evicts from the old end, one
// eviction at a time, as set by the one read port of each memory.
// After reset a pass clears the count and residency memories; no
// request is taken during it. A request is taken while a result still waits,
// and the result register holds until rsp_tready.
module byte_budget_lru_cluster_cache_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,   // operation
   input  logic [31:0]   req_tdata,   // list_index, entry_count
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [2:0]    rsp_tuser,   // status
   output logic [223:0]  rsp_tdata,   // result_index, fetch_offset, fetch_bytes,
                                      // evicted_count, bytes_in_use,
                                      // entries_cached, hit_count, miss_count
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [4:0]    csr_paddr,
   input  logic [63:0]   csr_pwdata,
   output logic [63:0]   csr_prdata,
   output logic          csr_pready
);

   localparam int IW = bblc_pkg::IDX_W;
   localparam int SW = bblc_pkg::SIZE_W;

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_LOOK  = 4'd2;
   localparam logic [3:0] S_SUM   = 4'd3;
   localparam logic [3:0] S_EVCHK = 4'd4;
   localparam logic [3:0] S_EVRD  = 4'd5;
   localparam logic [3:0] S_INS   = 4'd6;
   localparam logic [3:0] S_LINK  = 4'd7;
   localparam logic [3:0] S_CLR   = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   // configuration
   logic [bblc_pkg::OFF_W-1:0]   base_ff, base_in;
   logic [bblc_pkg::CODE_W-1:0]  code_ff, code_in;
   logic [bblc_pkg::BYTES_W-1:0] limit_ff, limit_in;

   // control and cache state
   logic [3:0]                   state_ff, state_in;
   logic [IW-1:0]                sweep_ff, sweep_in;
   logic [IW-1:0]                idx_ff, idx_in;
   logic [IW-1:0]                newest_ff, newest_in;
   logic [IW-1:0]                oldest_ff, oldest_in;
   logic [bblc_pkg::BYTES_W-1:0] used_ff, used_in;
   logic [bblc_pkg::TOT_W-1:0]   total_ff, total_in;
   logic [bblc_pkg::CTR_W-1:0]   hits_ff, hits_in;
   logic [bblc_pkg::CTR_W-1:0]   misses_ff, misses_in;
   logic [2:0]                   status_ff, status_in;
   logic [bblc_pkg::OFF_W-1:0]   foff_ff, foff_in;
   logic [SW-1:0]                need_ff, need_in;
   logic [bblc_pkg::TOT_W-1:0]   evict_ff, evict_in;
   logic                         ins_ff, ins_in;
   logic [IW:0]                  walk_ff, walk_in;
   logic                         v1_ff, v1_in;
   logic                         v2_ff, v2_in;
   logic [SW-1:0]                prod_ff, prod_in;
   logic                         rvalid_ff, rvalid_in;
   logic [2:0]                   rstat_ff, rstat_in;
   logic [223:0]                 rdata_ff, rdata_in;

   // memories
   logic                         cnt_we, rh_we, nw_we, ol_we;
   logic [IW-1:0]                cnt_wa, cnt_ra, rh_wa, rh_ra, nw_wa, nw_ra, ol_wa, ol_ra;
   logic [bblc_pkg::CNT_W-1:0]   cnt_wd, cnt_rd;
   logic [bblc_pkg::HELD_W-1:0]  rh_wd, rh_rd;
   logic [IW-1:0]                nw_wd, nw_rd, ol_wd, ol_rd;

   bblc_ram #(.WIDTH(bblc_pkg::CNT_W), .DEPTH(bblc_pkg::NLIST)) u_count (
      .clock(clock), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
      .raddr(cnt_ra), .rdata(cnt_rd));
   bblc_ram #(.WIDTH(bblc_pkg::HELD_W), .DEPTH(bblc_pkg::NLIST)) u_held (
      .clock(clock), .we(rh_we), .waddr(rh_wa), .wdata(rh_wd),
      .raddr(rh_ra), .rdata(rh_rd));
   bblc_ram #(.WIDTH(IW), .DEPTH(bblc_pkg::NLIST)) u_newer (
      .clock(clock), .we(nw_we), .waddr(nw_wa), .wdata(nw_wd),
      .raddr(nw_ra), .rdata(nw_rd));
   bblc_ram #(.WIDTH(IW), .DEPTH(bblc_pkg::NLIST)) u_older (
      .clock(clock), .we(ol_we), .waddr(ol_wa), .wdata(ol_wd),
      .raddr(ol_ra), .rdata(ol_rd));

   logic                         req_fire, csr_wr;
   logic [1:0]                   req_op;
   logic [IW-1:0]                req_idx;
   logic [bblc_pkg::CNT_W-1:0]   req_cnt;
   logic [SW-1:0]                mul;
   logic [bblc_pkg::OFF_W:0]     off_sum;
   logic [bblc_pkg::BYTES_W:0]   used_need;
   logic [bblc_pkg::BYTES_W-1:0] held_ext;
   logic                         over, slot_free, walk_go;
   logic [2:0]                   csr_sel;

   assign req_op   = req_tuser;
   assign req_idx  = req_tdata[IW-1:0];
   assign req_cnt  = req_tdata[IW +: bblc_pkg::CNT_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tuser  = rstat_ff;
   assign rsp_tdata  = rdata_ff;

   assign csr_pready = 1'b1;
   assign csr_sel    = {1'b0, csr_paddr[4:3]};
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_sel)
         bblc_pkg::CSR_BASE:  csr_prdata = {16'd0, base_ff};
         bblc_pkg::CSR_CODE:  csr_prdata = {55'd0, code_ff};
         bblc_pkg::CSR_LIMIT: csr_prdata = {24'd0, limit_ff};
         default:             csr_prdata = 64'd0;
      endcase
   end

   assign mul       = cnt_rd * (SW'(code_ff) + SW'(bblc_pkg::ID_BYTES));
   assign off_sum   = {1'b0, foff_ff} + (bblc_pkg::OFF_W+1)'(prod_ff);
   assign used_need = {1'b0, used_ff} + (bblc_pkg::BYTES_W+1)'(need_ff);
   assign held_ext  = bblc_pkg::BYTES_W'(rh_rd[SW-1:0]);
   assign over      = (limit_ff != '0) && (total_ff != '0) &&
                      (used_need > {1'b0, limit_ff});
   assign slot_free = !rvalid_ff || rsp_tready;
   assign walk_go   = walk_ff < {1'b0, idx_ff};

   always_comb begin
      base_in   = base_ff;
      code_in   = code_ff;
      limit_in  = limit_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            bblc_pkg::CSR_BASE:  base_in  = csr_pwdata[bblc_pkg::OFF_W-1:0];
            bblc_pkg::CSR_CODE:  code_in  = csr_pwdata[bblc_pkg::CODE_W-1:0];
            bblc_pkg::CSR_LIMIT: limit_in = csr_pwdata[bblc_pkg::BYTES_W-1:0];
            default: ;
         endcase
      end

      state_in  = state_ff;
      sweep_in  = sweep_ff;
      idx_in    = idx_ff;
      newest_in = newest_ff;
      oldest_in = oldest_ff;
      used_in   = used_ff;
      total_in  = total_ff;
      hits_in   = hits_ff;
      misses_in = misses_ff;
      status_in = status_ff;
      foff_in   = foff_ff;
      need_in   = need_ff;
      evict_in  = evict_ff;
      ins_in    = ins_ff;
      walk_in   = walk_ff;
      v1_in     = 1'b0;
      v2_in     = v1_ff;
      prod_in   = prod_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rstat_in  = rstat_ff;
      rdata_in  = rdata_ff;

      cnt_we = 1'b0; cnt_wa = req_idx; cnt_wd = req_cnt; cnt_ra = req_idx;
      rh_we  = 1'b0; rh_wa  = idx_ff;  rh_wd  = '0;      rh_ra  = req_idx;
      nw_we  = 1'b0; nw_wa  = ol_rd;   nw_wd  = nw_rd;   nw_ra  = req_idx;
      ol_we  = 1'b0; ol_wa  = nw_rd;   ol_wd  = ol_rd;   ol_ra  = req_idx;

      unique case (state_ff)
         S_INIT: begin
            cnt_we = 1'b1; cnt_wa = sweep_ff; cnt_wd = '0;
            rh_we  = 1'b1; rh_wa  = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == IW'(bblc_pkg::NLIST - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               idx_in   = req_idx;
               foff_in  = '0;
               need_in  = '0;
               evict_in = '0;
               ins_in   = 1'b0;
               case (req_op)
                  bblc_pkg::OP_LOAD: begin
                     cnt_we    = 1'b1;
                     status_in = bblc_pkg::ST_LOADED;
                     state_in  = S_DONE;
                  end
                  bblc_pkg::OP_ACCESS: begin
                     state_in = S_LOOK;
                  end
                  bblc_pkg::OP_CLEAR: begin
                     idx_in    = '0;
                     newest_in = '0;
                     oldest_in = '0;
                     used_in   = '0;
                     total_in  = '0;
                     hits_in   = '0;
                     misses_in = '0;
                     sweep_in  = '0;
                     status_in = bblc_pkg::ST_CLEARED;
                     state_in  = S_CLR;
                  end
                  default: ;
               endcase
            end
         end
         S_LOOK: begin
            if (rh_rd[SW]) begin
               hits_in   = (hits_ff == '1) ? hits_ff : hits_ff + 1'b1;
               status_in = bblc_pkg::ST_HIT;
               if (idx_ff == newest_ff) begin
                  state_in = S_DONE;
               end else begin
                  // unlink from the middle or from the old end, then relink
                  if (idx_ff == oldest_ff) begin
                     oldest_in = nw_rd;
                  end else begin
                     nw_we = 1'b1;
                     ol_we = 1'b1;
                  end
                  state_in = S_LINK;
               end
            end else begin
               misses_in = (misses_ff == '1) ? misses_ff : misses_ff + 1'b1;
               ins_in    = 1'b1;
               if (cnt_rd == '0) begin
                  rh_we     = 1'b1;
                  rh_wd     = {1'b1, {SW{1'b0}}};
                  status_in = bblc_pkg::ST_EMPTY;
                  state_in  = S_LINK;
               end else begin
                  need_in   = mul;
                  foff_in   = base_ff;
                  walk_in   = '0;
                  status_in = bblc_pkg::ST_FETCHED;
                  state_in  = S_SUM;
               end
            end
         end
         S_SUM: begin
            cnt_ra = walk_ff[IW-1:0];
            if (walk_go) begin
               v1_in   = 1'b1;
               walk_in = walk_ff + 1'b1;
            end
            if (v1_ff) begin
               prod_in = mul;
            end
            if (v2_ff) begin
               foff_in = off_sum[bblc_pkg::OFF_W] ? '1 : off_sum[bblc_pkg::OFF_W-1:0];
            end
            if (!walk_go && !v1_ff && !v2_ff) begin
               state_in = S_EVCHK;
            end
         end
         S_EVCHK: begin
            rh_ra = oldest_ff;
            nw_ra = oldest_ff;
            state_in = over ? S_EVRD : S_INS;
         end
         S_EVRD: begin
            rh_we = 1'b1;
            rh_wa = oldest_ff;
            if (total_ff <= 1) begin
               total_in = '0;
            end else begin
               oldest_in = nw_rd;
               total_in  = total_ff - 1'b1;
            end
            used_in  = (held_ext > used_ff) ? '0 : used_ff - held_ext;
            evict_in = evict_ff + 1'b1;
            state_in = S_EVCHK;
         end
         S_INS: begin
            rh_we   = 1'b1;
            rh_wd   = {1'b1, need_ff};
            used_in = used_need[bblc_pkg::BYTES_W] ? '1 : used_need[bblc_pkg::BYTES_W-1:0];
            state_in = S_LINK;
         end
         S_LINK: begin
            if (total_ff == '0) begin
               oldest_in = idx_ff;
            end else begin
               nw_we = 1'b1; nw_wa = newest_ff; nw_wd = idx_ff;
               ol_we = 1'b1; ol_wa = idx_ff;    ol_wd = newest_ff;
            end
            newest_in = idx_ff;
            if (ins_ff) begin
               total_in = total_ff + 1'b1;
            end
            state_in = S_DONE;
         end
         S_CLR: begin
            rh_we = 1'b1;
            rh_wa = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == IW'(bblc_pkg::NLIST - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rvalid_in = 1'b1;
               rstat_in  = status_ff;
               rdata_in  = {misses_ff, hits_ff, total_ff, used_ff, evict_ff,
                            bblc_pkg::BYTES_W'(need_ff), foff_ff, idx_ff};
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         code_ff   <= bblc_pkg::CODE_RESET;
         limit_ff  <= '0;
         state_ff  <= S_INIT;
         sweep_ff  <= '0;
         newest_ff <= '0;
         oldest_ff <= '0;
         used_ff   <= '0;
         total_ff  <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         base_ff   <= base_in;
         code_ff   <= code_in;
         limit_ff  <= limit_in;
         state_ff  <= state_in;
         sweep_ff  <= sweep_in;
         newest_ff <= newest_in;
         oldest_ff <= oldest_in;
         used_ff   <= used_in;
         total_ff  <= total_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      status_ff <= status_in;
      foff_ff   <= foff_in;
      need_ff   <= need_in;
      evict_ff  <= evict_in;
      ins_ff    <= ins_in;
      walk_ff   <= walk_in;
      prod_ff   <= prod_in;
      rstat_ff  <= rstat_in;
      rdata_ff  <= rdata_in;
   end

endmodule

FILE: sv/bblc_checker.sv
// Port-level checks for the byte-budget LRU cluster cache, bound to the top level.
module bblc_checker (
   input logic          clock,
   input logic          reset,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [2:0]    rsp_tuser,
   input logic [223:0]  rsp_tdata
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bblc_pkg::ST_CLEARED |->
         rsp_tdata[223:149] == '0 && rsp_tdata[9:0] == '0)
      else $error("clear left counters or residency");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != bblc_pkg::ST_FETCHED |-> rsp_tdata[97:10] == '0)
      else $error("fetch fields set outside a fetched miss");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[159:149] <= 11'd1024 && rsp_tuser <= bblc_pkg::ST_CLEARED)
      else $error("resident count or status out of range");

endmodule

bind byte_budget_lru_cluster_cache_top bblc_checker u_bblc_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata));
